// File: rtl/gcr_pkg.sv
// Shared types, constants and the quarter-wave sine table for the grid column raycaster.
package gcr_pkg;

	localparam int QUARTER = 16384;
	// 2^32 minus round(cos(0.01)^2 * 2^32)
	localparam logic [18:0] COS2_GAP = 19'd429482;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE_DIV,
		ST_SIN_X,
		ST_SIN_Y,
		ST_MARCH,
		ST_EDGE,
		ST_CEIL_DIV,
		ST_SHADE_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		REG_MAP0   = 3'd0,
		REG_MAP1   = 3'd1,
		REG_MAP2   = 3'd2,
		REG_MAP3   = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5,
		REG_FOV    = 3'd6,
		REG_DEPTH  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_ANGLE,
		DIV_CEIL,
		DIV_SHADE
	} div_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     angle_take;
		logic     sin_x;
		logic     sin_y;
		logic     march_init;
		logic     march_step;
		logic     edge_step;
		logic     ceil_take;
		logic     shade_take;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic march_stop;
		logic wall_hit;
		logic edge_done;
	} stat_t;

	function automatic logic [14:0] sine_tab(input logic [6:0] i);
		logic [14:0] r;
		case (i)
			7'd0: r = 15'd0;         7'd1: r = 15'd402;       7'd2: r = 15'd804;
			7'd3: r = 15'd1205;      7'd4: r = 15'd1606;      7'd5: r = 15'd2006;
			7'd6: r = 15'd2404;      7'd7: r = 15'd2801;      7'd8: r = 15'd3196;
			7'd9: r = 15'd3590;      7'd10: r = 15'd3981;     7'd11: r = 15'd4370;
			7'd12: r = 15'd4756;     7'd13: r = 15'd5139;     7'd14: r = 15'd5520;
			7'd15: r = 15'd5897;     7'd16: r = 15'd6270;     7'd17: r = 15'd6639;
			7'd18: r = 15'd7005;     7'd19: r = 15'd7366;     7'd20: r = 15'd7723;
			7'd21: r = 15'd8076;     7'd22: r = 15'd8423;     7'd23: r = 15'd8765;
			7'd24: r = 15'd9102;     7'd25: r = 15'd9434;     7'd26: r = 15'd9760;
			7'd27: r = 15'd10080;    7'd28: r = 15'd10394;    7'd29: r = 15'd10702;
			7'd30: r = 15'd11003;    7'd31: r = 15'd11297;    7'd32: r = 15'd11585;
			7'd33: r = 15'd11866;    7'd34: r = 15'd12140;    7'd35: r = 15'd12406;
			7'd36: r = 15'd12665;    7'd37: r = 15'd12916;    7'd38: r = 15'd13160;
			7'd39: r = 15'd13395;    7'd40: r = 15'd13623;    7'd41: r = 15'd13842;
			7'd42: r = 15'd14053;    7'd43: r = 15'd14256;    7'd44: r = 15'd14449;
			7'd45: r = 15'd14635;    7'd46: r = 15'd14811;    7'd47: r = 15'd14979;
			7'd48: r = 15'd15137;    7'd49: r = 15'd15286;    7'd50: r = 15'd15426;
			7'd51: r = 15'd15557;    7'd52: r = 15'd15679;    7'd53: r = 15'd15791;
			7'd54: r = 15'd15893;    7'd55: r = 15'd15986;    7'd56: r = 15'd16069;
			7'd57: r = 15'd16143;    7'd58: r = 15'd16207;    7'd59: r = 15'd16261;
			7'd60: r = 15'd16305;    7'd61: r = 15'd16340;    7'd62: r = 15'd16364;
			7'd63: r = 15'd16379;    7'd64: r = 15'd16384;
			default: r = 15'd16384;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/gcr_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned.
module gcr_divider
	import gcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [23:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);
	logic [23:0] rem_q;
	logic [23:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [24:0] trial;

	assign trial = {rem_q, quo_q[23]} - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= {rem_q[22:0], quo_q[23]};
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// File: rtl/gcr_datapath.sv
// Datapath: ray angle, sine lookup, march, edge test and output arithmetic.
module gcr_datapath
	import gcr_pkg::*;
#(
	parameter int MAP_SIDE          = 16,
	parameter int MAX_SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	output stat_t       stat,
	input  logic [15:0] player_x,
	input  logic [15:0] player_y,
	input  logic [15:0] player_angle,
	input  logic [7:0]  column,
	input  logic [63:0] map_q [4],
	input  logic [8:0]  width_q,
	input  logic [6:0]  height_q,
	input  logic [15:0] fov_q,
	input  logic [9:0]  depth_q,
	output logic [6:0]  ceiling_row,
	output logic [6:0]  floor_row,
	output logic [2:0]  shade_index,
	output logic        edge_flag,
	output logic [9:0]  distance_steps
);
	logic [15:0] px_q, py_q, pa_q;
	logic [7:0]  col_q;
	logic [15:0] ray_q;
	logic signed [15:0] ex_q, ey_q;
	logic [9:0]  n_q;
	logic [9:0]  depth_eff;
	logic [6:0]  h_eff;
	logic        edge_q;
	logic signed [6:0] ceil_q;
	logic [2:0]  shade_q;
	logic        hit_q;

	assign depth_eff = (depth_q == 10'd0) ? 10'd1 : depth_q;
	assign h_eff = (height_q > 7'(MAX_SCREEN_HEIGHT)) ? 7'(MAX_SCREEN_HEIGHT) : height_q;

	// shared divider
	logic [23:0] div_a, div_b, div_quo;
	logic        div_done;
	logic [25:0] ceil_num;   // |H*(n-20)|
	logic        ceil_neg;

	assign ceil_neg = (n_q < 10'd20);
	assign ceil_num = ceil_neg ? 26'(h_eff) * 26'(10'd20 - n_q) : 26'(h_eff) * 26'(n_q - 10'd20);

	always_comb begin
		case (ctrl.div_sel)
			DIV_ANGLE: begin
				div_a = 24'(col_q) * 24'(fov_q);
				div_b = (width_q == 9'd0) ? 24'd1 : 24'(width_q);
			end
			DIV_CEIL: begin
				div_a = ceil_num[23:0];
				div_b = {13'd0, n_q, 1'b0};
			end
			DIV_SHADE: begin
				div_a = 24'(n_q) * 24'd5;
				div_b = 24'(depth_eff);
			end
			default: begin
				div_a = '0;
				div_b = 24'd1;
			end
		endcase
	end

	gcr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sine of a selected angle
	logic [15:0] sin_ang;
	logic [1:0]  quad;
	logic [14:0] rr, rq;
	logic [14:0] t0, t1, qs;
	logic [23:0] prod;
	logic signed [15:0] sin_val;

	assign sin_ang = ctrl.sin_y ? ray_q + 16'(QUARTER) : ray_q;
	assign quad = sin_ang[15:14];
	assign rr = {1'b0, sin_ang[13:0]};
	assign rq = quad[0] ? 15'(QUARTER) - rr : rr;
	always_comb begin
		t0 = sine_tab(7'(rq[14:8]));
		t1 = sine_tab(7'(rq[14:8]) + 7'd1);
		prod = 24'(t1 - t0) * 24'(rq[7:0]);
		if (rq[14])
			qs = 15'(QUARTER);
		else
			qs = t0 + prod[22:8];
		sin_val = quad[1] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
	end

	// march position accumulators: player*40 + e*n
	logic signed [23:0] acc_x_q, acc_y_q;
	logic signed [23:0] nx, ny;
	logic [3:0] cx_q, cy_q;
	logic [4:0] tx, ty;
	logic       outx, outy, out_map, wall;
	logic [63:0] wrow;

	assign nx = acc_x_q + 24'(ex_q);
	assign ny = acc_y_q + 24'(ey_q);

	// truncation toward zero; a negative sum above -163840 truncates to 0.
	// 163840 = 5 * 2^15: drop 15 bits, then divide by 5 as (x * 205) >> 10
	function automatic logic [5:0] cell_of(input logic signed [23:0] v, output logic bad);
		logic [5:0]  c;
		logic [15:0] p;
		bad = 1'b0;
		c = '0;
		p = 16'(v[22:15]) * 16'd205;
		if (v <= -24'sd163840) bad = 1'b1;
		else if (v < 0) c = '0;
		else c = p[15:10];
		return c;
	endfunction

	logic [5:0] cxw, cyw;
	logic bx, by;
	always_comb begin
		cxw = cell_of(nx, bx);
		cyw = cell_of(ny, by);
		outx = bx || (cxw >= 6'(MAP_SIDE));
		outy = by || (cyw >= 6'(MAP_SIDE));
		tx = cxw[4:0];
		ty = cyw[4:0];
		out_map = outx || outy;
		wrow = map_q[ty[3:2]];
		wall = wrow[{ty[1:0], tx[3:0]}];
	end

	// edge test: four corners, pick the two nearest, then one aim check per cycle
	logic [2:0] ek_q;
	logic signed [18:0] vx, vy;
	logic [37:0] d2;
	logic signed [36:0] dt;
	logic [37:0] d2_q [4];
	logic signed [36:0] dt_q [4];
	logic [1:0]  f_idx, s_idx;
	logic [1:0]  s_sel_q;
	logic signed [36:0] aim_dt_q;
	logic [37:0] aim_d2_q;
	logic        aim_q, aim_now;

	assign vx = 19'($signed({1'b0, 4'(cx_q + 4'(ek_q[1])), 12'd0}) + 19'sd0)
		- $signed({3'b0, px_q});
	assign vy = 19'($signed({1'b0, 4'(cy_q + 4'(ek_q[0])), 12'd0}) + 19'sd0)
		- $signed({3'b0, py_q});
	logic signed [19:0] vxe, vye;
	assign vxe = {1'b0, 4'd0, 15'd0} + (ek_q[1] && cx_q == 4'hf ? 20'sd65536 : 20'sd0)
		+ 20'(vx);
	assign vye = (ek_q[0] && cy_q == 4'hf ? 20'sd65536 : 20'sd0) + 20'(vy);
	assign d2 = 38'(vxe * vxe) + 38'(vye * vye);
	assign dt = 37'(ex_q * vxe) + 37'(ey_q * vye);

	always_comb begin
		f_idx = 2'd0;
		for (int k = 1; k < 4; k++)
			if (d2_q[k] < d2_q[f_idx]) f_idx = 2'(k);
		s_idx = (f_idx == 2'd0) ? 2'd1 : 2'd0;
		for (int k = 0; k < 4; k++)
			if (2'(k) != f_idx && d2_q[k] < d2_q[s_idx]) s_idx = 2'(k);
	end

	// (4*dot)^2 > K*|v|^2 with K = 2^32 - gap; dot < 2^31 and |v|^2 <= 2^33
	function automatic logic aims(input logic signed [36:0] d, input logic [37:0] q);
		logic [61:0] sq;
		logic [52:0] kq;
		logic [67:0] l, r;
		sq = d[30:0] * d[30:0];
		kq = q[33:0] * COS2_GAP;
		l = {2'b00, sq, 4'b0000} + 68'(kq);
		r = {q[35:0], 32'd0};
		return (d > 0) && (l > r);
	endfunction

	assign aim_now = aims(aim_dt_q, aim_d2_q);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			px_q <= player_x; py_q <= player_y; pa_q <= player_angle; col_q <= column;
			edge_q <= 1'b0;
		end
		if (ctrl.angle_take)
			ray_q <= pa_q - {1'b0, fov_q[15:1]} + div_quo[15:0];
		if (ctrl.sin_x) ex_q <= sin_val;
		if (ctrl.sin_y) ey_q <= sin_val;
		if (ctrl.march_init) begin
			acc_x_q <= 24'(px_q) * 24'sd40;
			acc_y_q <= 24'(py_q) * 24'sd40;
			n_q <= '0;
			ek_q <= '0;
			hit_q <= 1'b0;
		end else if (ctrl.march_step) begin
			acc_x_q <= nx;
			acc_y_q <= ny;
			n_q <= n_q + 10'd1;
			cx_q <= tx[3:0];
			cy_q <= ty[3:0];
			if (out_map) n_q <= depth_eff;
			hit_q <= wall && !out_map;
		end
		if (ctrl.edge_step) begin
			if (ek_q[2]) begin
				case (ek_q[1:0])
					2'd0: begin
						aim_dt_q <= dt_q[f_idx];
						aim_d2_q <= d2_q[f_idx];
						s_sel_q <= s_idx;
					end
					2'd1: begin
						aim_q <= aim_now;
						aim_dt_q <= dt_q[s_sel_q];
						aim_d2_q <= d2_q[s_sel_q];
					end
					default: edge_q <= aim_q || aim_now;
				endcase
			end else begin
				d2_q[ek_q[1:0]] <= d2;
				dt_q[ek_q[1:0]] <= dt;
			end
			ek_q <= ek_q + 3'd1;
		end
		if (ctrl.ceil_take) begin
			if (ceil_neg)
				ceil_q <= (div_quo > 24'd1) ? -7'sd1 : -$signed(div_quo[6:0]);
			else
				ceil_q <= $signed(div_quo[6:0]);
		end
		if (ctrl.shade_take)
			shade_q <= (div_quo > 24'd5) ? 3'd5 : div_quo[2:0];
	end

	assign stat.div_done   = div_done;
	assign stat.march_stop = out_map || wall || (n_q + 10'd1 >= depth_eff);
	assign stat.wall_hit   = wall && !out_map;
	assign stat.edge_done  = (ek_q == 3'd6);

	assign ceiling_row    = ceil_q;
	assign floor_row      = h_eff - ceil_q;
	assign shade_index    = shade_q;
	assign edge_flag      = edge_q && hit_q;
	assign distance_steps = n_q;
endmodule

// File: rtl/gcr_controller.sv
// Controller state machine sequencing angle, sine, march, edge and division phases.
module gcr_controller
	import gcr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output ctrl_t ctrl
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_ANGLE_DIV;
			ST_ANGLE_DIV: if (stat.div_done) state_d = ST_SIN_X;
			ST_SIN_X:     state_d = ST_SIN_Y;
			ST_SIN_Y:     state_d = ST_MARCH;
			ST_MARCH:     if (stat.march_stop)
				state_d = stat.wall_hit ? ST_EDGE : ST_CEIL_DIV;
			ST_EDGE:      if (stat.edge_done) state_d = ST_CEIL_DIV;
			ST_CEIL_DIV:  if (stat.div_done) state_d = ST_SHADE_DIV;
			ST_SHADE_DIV: if (stat.div_done) state_d = ST_DONE;
			ST_DONE:      if (!out_stall) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	logic entered_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) entered_q <= 1'b0;
		else entered_q <= (state_d != state_q);
	end

	always_comb begin
		ctrl = '0;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DONE);
		case (state_q)
			ST_IDLE: ctrl.load = in_valid;
			ST_ANGLE_DIV: begin
				ctrl.div_sel = DIV_ANGLE;
				ctrl.div_start = entered_q;
				ctrl.angle_take = stat.div_done;
			end
			ST_SIN_X: ctrl.sin_x = 1'b1;
			ST_SIN_Y: begin
				ctrl.sin_y = 1'b1;
				ctrl.march_init = 1'b1;
			end
			ST_MARCH: ctrl.march_step = 1'b1;
			ST_EDGE: ctrl.edge_step = 1'b1;
			ST_CEIL_DIV: begin
				ctrl.div_sel = DIV_CEIL;
				ctrl.div_start = entered_q;
				ctrl.ceil_take = stat.div_done;
			end
			ST_SHADE_DIV: begin
				ctrl.div_sel = DIV_SHADE;
				ctrl.div_start = entered_q;
				ctrl.shade_take = stat.div_done;
			end
			default: ;
		endcase
	end
endmodule

// File: rtl/grid_column_raycaster.sv
// Top level of the grid column raycaster: config registers, controller and datapath.
//  channel | valid      | stall      | payload
//  in      | in_valid   | in_stall   | player_x, player_y, player_angle, column
//  out     | out_valid  | out_stall  | ceiling_row, floor_row, shade_index, edge_flag,
//          |            |            | distance_steps
// One transaction at a time: in_stall stays high from one input acceptance until the result
// is taken. Each ray passes through the angle division, the two sine lookups, the march
// (up to 1023 steps), the edge test on a wall hit, then the ceiling and shade divisions;
// three divider passes in all.
// Reset clears the map and loads default screen settings; out_stall holds the result.
module grid_column_raycaster
	import gcr_pkg::*;
#(
	parameter int MAP_SIDE          = 16,
	parameter int MAX_SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] player_x,
	input  logic [15:0] player_y,
	input  logic [15:0] player_angle,
	input  logic [7:0]  column,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [6:0] ceiling_row,
	output logic [6:0]  floor_row,
	output logic [2:0]  shade_index,
	output logic        edge_flag,
	output logic [9:0]  distance_steps,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [63:0] map_q [4];
	logic [8:0]  width_q;
	logic [6:0]  height_q;
	logic [15:0] fov_q;
	logic [9:0]  depth_q;
	ctrl_t ctrl;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) map_q[i] <= '0;
			width_q  <= 9'd120;
			height_q <= 7'd40;
			fov_q    <= 16'd8192;
			depth_q  <= 10'd160;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAP0:   map_q[0] <= cfg_data;
				REG_MAP1:   map_q[1] <= cfg_data;
				REG_MAP2:   map_q[2] <= cfg_data;
				REG_MAP3:   map_q[3] <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[8:0];
				REG_HEIGHT: height_q <= cfg_data[6:0];
				REG_FOV:    fov_q    <= cfg_data[15:0];
				REG_DEPTH:  depth_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	gcr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	gcr_datapath #(
		.MAP_SIDE          (MAP_SIDE),
		.MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.player_x       (player_x),
		.player_y       (player_y),
		.player_angle   (player_angle),
		.column         (column),
		.map_q          (map_q),
		.width_q        (width_q),
		.height_q       (height_q),
		.fov_q          (fov_q),
		.depth_q        (depth_q),
		.ceiling_row    (ceiling_row),
		.floor_row      (floor_row),
		.shade_index    (shade_index),
		.edge_flag      (edge_flag),
		.distance_steps (distance_steps)
	);
endmodule

// File: bench/grid_column_raycaster_tb.sv
// Self-checking bench for grid_column_raycaster: directed rays, then randomized map and view phases.
`timescale 1ns / 1ps

module grid_column_raycaster_tb;
	import gcr_pkg::*;

	localparam int  LIMIT_CYCLES = 2000000;
	localparam int  LONG_HOLD    = 300;
	localparam int  N_TYPED      = 8;
	localparam int  N_ROWS       = 20;
	localparam longint unsigned COS2_SQ = 64'd4294537814;

	localparam int SIN_Q14 [65] = '{
		0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590, 3981, 4370,
		4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
		9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297, 11585, 11866, 12140,
		12406, 12665, 12916, 13160, 13395, 13623, 13842, 14053, 14256, 14449,
		14635, 14811, 14979, 15137, 15286, 15426, 15557, 15679, 15791, 15893,
		15986, 16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384};

	typedef struct {
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] ang;
		logic [7:0]  col;
	} ray_req_t;

	typedef struct {
		logic [6:0] ceil_r;
		logic [6:0] floor_r;
		logic [2:0] shade;
		logic       near_edge;
		logic [9:0] steps;
	} column_t;

	// empty map at reset settings: every ray runs out at 160 steps
	localparam column_t OPEN_MAP_COLUMN = '{7'd17, 7'd23, 3'd5, 1'b0, 10'd160};

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [15:0] player_x = 0;
	logic [15:0] player_y = 0;
	logic [15:0] player_angle = 0;
	logic [7:0]  column = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic signed [6:0] ceiling_row;
	logic [6:0]  floor_row;
	logic [2:0]  shade_index;
	logic        edge_flag;
	logic [9:0]  distance_steps;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = 0;
	logic [63:0] cfg_data = 0;

	grid_column_raycaster dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// shadow registers
	logic [63:0] wall_rows [4];
	logic [8:0]  scr_w;
	logic [6:0]  scr_h;
	logic [15:0] fov;
	logic [9:0]  depth_lim;

	column_t pending_columns [$];
	int      errors = 0;
	int      cycles = 0;
	int      burst_left = 0;
	bit      hold_req = 0;

	function automatic int quarter_sin(int r);
		int i, f;
		if (r >= 16384)
			return 16384;
		i = r >> 8;
		f = r & 255;
		return SIN_Q14[i] + (((SIN_Q14[i+1] - SIN_Q14[i]) * f) >> 8);
	endfunction

	function automatic int sin_q14(int a);
		int r;
		r = a & 16'h3FFF;
		case ((a >> 14) & 3)
			0: return quarter_sin(r);
			1: return quarter_sin(16384 - r);
			2: return -quarter_sin(r);
			default: return -quarter_sin(16384 - r);
		endcase
	endfunction

	function automatic bit wall_at(int x, int y);
		logic [63:0] w;
		w = wall_rows[(y >> 2) & 3];
		return w[((y & 3) * 16 + (x & 15)) & 63];
	endfunction

	// cos^2 test without sqrt: (4*dot)^2 > K * |v|^2
	function automatic bit aims_at(longint dot, longint d2);
		logic [127:0] a, lhs, rhs;
		if (dot <= 0)
			return 0;
		a = 128'(dot) * 128'd4;
		lhs = a * a;
		rhs = 128'(COS2_SQ) * 128'(d2);
		return lhs > rhs;
	endfunction

	function automatic bit corner_hit(ray_req_t q, int ex, int ey, int cx, int cy);
		longint d2 [4];
		longint dt [4];
		longint vx, vy;
		int first, second;
		first = 0;
		second = -1;
		for (int k = 0; k < 4; k++) begin
			vx = longint'((cx + (k >> 1)) << 12) - longint'(q.px);
			vy = longint'((cy + (k & 1)) << 12) - longint'(q.py);
			d2[k] = vx * vx + vy * vy;
			dt[k] = longint'(ex) * vx + longint'(ey) * vy;
		end
		for (int k = 1; k < 4; k++)
			if (d2[k] < d2[first])
				first = k;
		for (int k = 0; k < 4; k++)
			if (k != first && (second < 0 || d2[k] < d2[second]))
				second = k;
		return aims_at(dt[first], d2[first]) || aims_at(dt[second], d2[second]);
	endfunction

	function automatic column_t cast_column(ray_req_t q);
		column_t c;
		int unsigned w, d, h, ray;
		int ex, ey, n, ceil_v, floor_v, sh;
		longint tx, ty;
		bit done, near;
		w = (scr_w == 0) ? 1 : scr_w;
		d = (depth_lim == 0) ? 1 : depth_lim;
		h = (scr_h > 64) ? 64 : scr_h;
		ray = (q.ang - (fov >> 1) + (q.col * fov) / w) & 16'hFFFF;
		ex = sin_q14(ray);
		ey = sin_q14((ray + 16384) & 16'hFFFF);
		n = 0;
		done = 0;
		near = 0;
		while (!done && n < d) begin
			n++;
			tx = (longint'(q.px) * 40 + longint'(ex) * n) / 163840;
			ty = (longint'(q.py) * 40 + longint'(ey) * n) / 163840;
			if (tx < 0 || tx >= 16 || ty < 0 || ty >= 16) begin
				done = 1;
				n = d;
			end else if (wall_at(int'(tx), int'(ty))) begin
				done = 1;
				near = corner_hit(q, ex, ey, int'(tx), int'(ty));
			end
		end
		ceil_v = (int'(h) * (n - 20)) / (2 * n);
		if (ceil_v < -1)
			ceil_v = -1;
		floor_v = int'(h) - ceil_v;
		sh = (5 * n) / d;
		if (sh > 5)
			sh = 5;
		c.ceil_r = ceil_v[6:0];
		c.floor_r = floor_v[6:0];
		c.shade = sh[2:0];
		c.near_edge = near;
		c.steps = n[9:0];
		return c;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		column_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_columns.size() == 0) begin
				report("unexpected transaction, ceiling_row", ceiling_row, 0);
			end else begin
				e = pending_columns.pop_front();
				if (ceiling_row !== e.ceil_r)
					report("ceiling_row", ceiling_row, $signed(e.ceil_r));
				if (floor_row !== e.floor_r)
					report("floor_row", floor_row, e.floor_r);
				if (shade_index !== e.shade)
					report("shade_index", shade_index, e.shade);
				if (edge_flag !== e.near_edge)
					report("edge_flag", edge_flag, e.near_edge);
				if (distance_steps !== e.steps)
					report("distance_steps", distance_steps, e.steps);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("grid_column_raycaster_tb: errors");
			$finish;
		end
	end

	// receiver: stall pattern, plus one long hold-off on request
	initial begin
		int hold_left, mode, mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = LONG_HOLD;
				out_stall <= 1;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(5, 60);
					mode = $urandom_range(0, 3);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	task automatic offer(ray_req_t q, bit typed);
		column_t want;
		player_x <= q.px;
		player_y <= q.py;
		player_angle <= q.ang;
		column <= q.col;
		in_valid <= 1;
		do
			@(posedge clk);
		while (in_stall);
		want = typed ? OPEN_MAP_COLUMN : cast_column(q);
		pending_columns = {pending_columns, want};
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_columns.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_MAP0:   wall_rows[0] = v;
			REG_MAP1:   wall_rows[1] = v;
			REG_MAP2:   wall_rows[2] = v;
			REG_MAP3:   wall_rows[3] = v;
			REG_WIDTH:  scr_w = v[8:0];
			REG_HEIGHT: scr_h = v[6:0];
			REG_FOV:    fov = v[15:0];
			REG_DEPTH:  depth_lim = v[9:0];
			default: ;
		endcase
	endtask

	// style: 0 empty, 1 border plus sparse interior, 2 random bits, 3 solid
	task automatic set_config(int w, int h, int f, int d, int style);
		logic [63:0] rows [4];
		for (int r = 0; r < 4; r++)
			rows[r] = {$urandom, $urandom};
		for (int y = 0; y < 16; y++)
			for (int x = 0; x < 16; x++)
				case (style)
					0: rows[y / 4][(y % 4) * 16 + x] = 0;
					1: rows[y / 4][(y % 4) * 16 + x] = (x == 0 || y == 0 || x == 15
						|| y == 15 || $urandom_range(0, 5) == 0);
					3: rows[y / 4][(y % 4) * 16 + x] = 1;
					default: ;
				endcase
		write_reg(REG_MAP0, rows[0]);
		write_reg(REG_MAP1, rows[1]);
		write_reg(REG_MAP2, rows[2]);
		write_reg(REG_MAP3, rows[3]);
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
		write_reg(REG_FOV, 64'(f));
		write_reg(REG_DEPTH, 64'(d));
	endtask

	ray_req_t ray_rows [N_ROWS] = '{
		'{16'h0000, 16'h0000, 16'h0000, 8'd0},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255},
		'{16'h8000, 16'h8000, 16'h4000, 8'd119},
		'{16'h8000, 16'h8000, 16'hC000, 8'd120},
		'{16'h1000, 16'hF000, 16'h8000, 8'd60},
		'{16'hFFFF, 16'h0000, 16'h2000, 8'd0},
		'{16'h0000, 16'hFFFF, 16'hE000, 8'd200},
		'{16'h7FFF, 16'h8001, 16'h0001, 8'd1},
		// border map from here on
		'{16'h3000, 16'h3000, 16'h0000, 8'd60},  // player on a corner
		'{16'h3000, 16'h3000, 16'h4000, 8'd60},
		'{16'h3000, 16'h3000, 16'h8000, 8'd60},
		'{16'h3000, 16'h3000, 16'hC000, 8'd60},
		'{16'h0800, 16'h0800, 16'h2000, 8'd0},   // starts inside a wall
		'{16'h8800, 16'h8800, 16'h2000, 8'd60},  // aimed at a block corner
		'{16'h8800, 16'h8800, 16'h6000, 8'd60},
		'{16'h8800, 16'h8800, 16'hA000, 8'd60},
		'{16'h8800, 16'h8800, 16'hE000, 8'd60},
		'{16'h8000, 16'h8000, 16'hFFFF, 8'd255}, // past the screen width
		'{16'hEFFF, 16'h1001, 16'h5555, 8'd119},
		'{16'h1001, 16'hEFFF, 16'hAAAA, 8'd0}};

	initial begin
		ray_req_t q;
		int w, h, f, d, style, n_items;
		wall_rows = '{default: 64'd0};
		scr_w = 120;
		scr_h = 40;
		fov = 8192;
		depth_lim = 160;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (i == N_TYPED) begin
				drain();
				set_config(120, 40, 8192, 160, 1);
			end
			offer(ray_rows[i], i < N_TYPED);
			pace();
		end

		for (int ph = 0; ph < 11; ph++) begin
			drain();
			style = $urandom_range(1, 3) == 1 ? $urandom_range(0, 3) : 1;
			w = $urandom_range(1, 256);
			h = $urandom_range(2, 64);
			f = $urandom_range(0, 65535);
			d = $urandom_range(20, 200);
			n_items = 52;
			case (ph)
				0: begin w = 1; h = 2; f = 0; d = 1; end
				1: begin w = 256; h = 64; f = 65535; d = 1023; n_items = 10; end
				2: begin w = 0; h = 0; d = 0; end
				3: begin w = 511; h = 127; end
				4: h = 1;
				default: ;
			endcase
			set_config(w, h, f, d, style);
			for (int k = 0; k < n_items; k++) begin
				if (ph == 5 && k == 3)
					hold_req = 1;
				if (ph == 6 && k == 20) begin
					in_valid <= 0;
					while (pending_columns.size() != 0)
						@(posedge clk);
				end
				if ($urandom_range(0, 4) == 0) begin
					q.px = $urandom;
					q.py = $urandom;
				end else begin
					q.px = $urandom_range(4096, 61439);
					q.py = $urandom_range(4096, 61439);
				end
				q.ang = $urandom;
				q.col = ($urandom_range(0, 5) == 0 || w == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, (w > 256 ? 256 : w) - 1);
				offer(q, 0);
				pace();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("grid_column_raycaster_tb: clean");
		else
			$display("grid_column_raycaster_tb: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/gcr_pkg.sv
rtl/gcr_divider.sv
rtl/gcr_datapath.sv
rtl/gcr_controller.sv
rtl/grid_column_raycaster.sv
bench/grid_column_raycaster_tb.sv
